// ===== src/tcc_pkg.sv =====
// Package for the touch coordinate conditioner.
// Holds payload and handshake structs, sizing constants, register indexes and
// sequencer states. Has no dependencies.
package tcc_pkg;

  // Window and screen geometry.
  localparam int WINDOW_SAMPLES = 8;
  localparam int MIN_VALID      = 3;
  localparam int RAW_W          = 12;
  localparam int COL_W          = 8;
  localparam int ROW_W          = 9;
  localparam int COL_MAX        = 239;
  localparam int ROW_MAX        = 319;

  // Accumulator and counter sizes follow from the window length.
  localparam int SUM_W  = $clog2(WINDOW_SAMPLES * ((1 << RAW_W) - 1) + 1);
  localparam int CNT_W  = $clog2(WINDOW_SAMPLES + 1);

  // Shared divider: the dividend holds a window sum or a scaled raw offset.
  localparam int PROD_W = $clog2(((1 << RAW_W) - 1) * ROW_MAX + 1);
  localparam int DIV_W  = (SUM_W > PROD_W) ? SUM_W : PROD_W;
  localparam int DVS_W  = RAW_W;
  localparam int STEP_W = $clog2(DIV_W + 1);
  // Signed width for a mapped value after negation and mirroring.
  localparam int MAP_W  = DIV_W + 2;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = RAW_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_X_RAW_MIN = 3'd0,
    CFG_X_RAW_MAX = 3'd1,
    CFG_Y_RAW_MIN = 3'd2,
    CFG_Y_RAW_MAX = 3'd3,
    CFG_SWAP_AXES = 3'd4,
    CFG_MIRROR_X  = 3'd5,
    CFG_MIRROR_Y  = 3'd6
  } cfg_idx_t;

  // Register reset values.
  localparam logic [RAW_W-1:0] X_RAW_MIN_RST = 12'd25;
  localparam logic [RAW_W-1:0] X_RAW_MAX_RST = 12'd222;
  localparam logic [RAW_W-1:0] Y_RAW_MIN_RST = 12'd31;
  localparam logic [RAW_W-1:0] Y_RAW_MAX_RST = 12'd281;

  typedef struct packed {
    logic [RAW_W-1:0] raw_x;
    logic [RAW_W-1:0] raw_y;
  } in_beat_t;

  typedef struct packed {
    logic             touched;
    logic [COL_W-1:0] screen_x;
    logic [ROW_W-1:0] screen_y;
  } out_beat_t;

  // Request and response of the shared divider.
  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_AVG_GO,
    ST_AVG_WAIT,
    ST_MAP_MUL,
    ST_MAP_GO,
    ST_MAP_WAIT,
    ST_FINISH
  } seq_state_t;

endpackage

// ===== src/touch_coordinate_conditioner.sv =====
// Top level of the touch coordinate conditioner: config registers, sequencer,
// mapping datapath and result register. Depends on tcc_pkg, tcc_accum, tcc_div.
//
//  Channel  Direction  Handshake           Beat
//  in_      in         in_valid/in_stall   raw_x, raw_y
//  out_     out        out_valid/out_stall touched, screen_x, screen_y
//  cfg_     in         cfg_valid/cfg_ready cfg_index, cfg_data
//
// While the sequencer is idle, in_stall is low and each sample is taken.
// The closing sample starts the sequencer: the shared 21-step divider runs
// four times (two averages, two axis mappings), plus a multiply state per axis.
// A window with fewer than three valid samples skips the divider and the mapping.
// Reset is synchronous and restores the register defaults and clears the window.
// A stalled result waits in the output register; the block keeps taking samples
// and holds only the next result until the register frees up.
module touch_coordinate_conditioner (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  tcc_pkg::in_beat_t                  in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output tcc_pkg::out_beat_t                 out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [tcc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tcc_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int RAW_W = tcc_pkg::RAW_W;

  // Configuration registers.
  logic [RAW_W-1:0] x_min_r, x_max_r, y_min_r, y_max_r;
  logic             swap_r, mir_x_r, mir_y_r;

  // Sequencer and datapath registers.
  tcc_pkg::seq_state_t          state_r, state_nxt;
  logic                         axis_r, axis_nxt;
  logic                         touch_r, touch_nxt;
  logic [RAW_W-1:0]             avg_x_r, avg_x_nxt;
  logic [RAW_W-1:0]             avg_y_r, avg_y_nxt;
  logic [tcc_pkg::DIV_W-1:0]    prod_r, prod_nxt;
  logic [RAW_W-1:0]             span_r, span_nxt;
  logic                         neg_r, neg_nxt;
  logic                         zero_r, zero_nxt;
  logic [tcc_pkg::COL_W-1:0]    scr_x_r, scr_x_nxt;
  logic [tcc_pkg::ROW_W-1:0]    scr_y_r, scr_y_nxt;
  logic                         out_valid_r, out_valid_nxt;
  tcc_pkg::out_beat_t           out_data_r, out_data_nxt;

  // Accumulator and divider hookup.
  logic                         take;
  logic                         clear;
  logic [tcc_pkg::SUM_W-1:0]    sum_x, sum_y;
  logic [tcc_pkg::CNT_W-1:0]    valid_count;
  logic                         last;
  tcc_pkg::div_req_t            div_req;
  tcc_pkg::div_rsp_t            div_rsp;

  // Mapping datapath signals.
  logic [RAW_W-1:0]             v_sel, lo_sel, hi_sel;
  logic [tcc_pkg::ROW_W-1:0]    top_sel;
  logic                         mir_sel;
  logic [RAW_W:0]               diff, diff_abs, span, span_abs;
  logic [tcc_pkg::MAP_W-1:0]    q_ext, mapped, mirrored, top_ext;
  logic [tcc_pkg::ROW_W-1:0]    clamped;
  logic                         slot_free;

  assign take      = in_valid && !in_stall;
  assign in_stall  = (state_r != tcc_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;

  tcc_accum u_accum (
    .clk         (clk),
    .rst_n       (rst_n),
    .take        (take),
    .beat        (in_data),
    .clear       (clear),
    .sum_x       (sum_x),
    .sum_y       (sum_y),
    .valid_count (valid_count),
    .last        (last)
  );

  tcc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Configuration writes; an index past the list is dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_min_r <= tcc_pkg::X_RAW_MIN_RST;
      x_max_r <= tcc_pkg::X_RAW_MAX_RST;
      y_min_r <= tcc_pkg::Y_RAW_MIN_RST;
      y_max_r <= tcc_pkg::Y_RAW_MAX_RST;
      swap_r  <= 1'b1;
      mir_x_r <= 1'b1;
      mir_y_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tcc_pkg::CFG_X_RAW_MIN: x_min_r <= cfg_data;
        tcc_pkg::CFG_X_RAW_MAX: x_max_r <= cfg_data;
        tcc_pkg::CFG_Y_RAW_MIN: y_min_r <= cfg_data;
        tcc_pkg::CFG_Y_RAW_MAX: y_max_r <= cfg_data;
        tcc_pkg::CFG_SWAP_AXES: swap_r  <= cfg_data[0];
        tcc_pkg::CFG_MIRROR_X:  mir_x_r <= cfg_data[0];
        tcc_pkg::CFG_MIRROR_Y:  mir_y_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Axis selection for the mapping step, with the optional swap.
  always_comb begin
    if (axis_r) begin
      v_sel   = swap_r ? avg_x_r : avg_y_r;
      lo_sel  = y_min_r;
      hi_sel  = y_max_r;
      top_sel = tcc_pkg::ROW_W'(tcc_pkg::ROW_MAX);
      mir_sel = mir_y_r;
    end else begin
      v_sel   = swap_r ? avg_y_r : avg_x_r;
      lo_sel  = x_min_r;
      hi_sel  = x_max_r;
      top_sel = tcc_pkg::ROW_W'(tcc_pkg::COL_MAX);
      mir_sel = mir_x_r;
    end
    // Signed offsets split into magnitude and sign for the unsigned divider.
    diff     = {1'b0, v_sel} - {1'b0, lo_sel};
    diff_abs = diff[RAW_W] ? (RAW_W+1)'(-diff) : diff;
    span     = {1'b0, hi_sel} - {1'b0, lo_sel};
    span_abs = span[RAW_W] ? (RAW_W+1)'(-span) : span;
  end

  // Sign restore, mirror and clamp of a quotient.
  always_comb begin
    q_ext    = tcc_pkg::MAP_W'(div_rsp.quotient);
    if (zero_r) begin
      mapped = '0;
    end else begin
      mapped = neg_r ? tcc_pkg::MAP_W'(-q_ext) : q_ext;
    end
    top_ext  = tcc_pkg::MAP_W'(top_sel);
    mirrored = mir_sel ? tcc_pkg::MAP_W'(top_ext - mapped) : mapped;
    priority if (mirrored[tcc_pkg::MAP_W-1]) begin
      clamped = '0;
    end else if (mirrored > top_ext) begin
      clamped = top_sel;
    end else begin
      clamped = mirrored[tcc_pkg::ROW_W-1:0];
    end
  end

  assign slot_free = !out_valid_r || !out_stall;

  // Sequencer: next state and datapath updates.
  always_comb begin
    state_nxt     = state_r;
    axis_nxt      = axis_r;
    touch_nxt     = touch_r;
    avg_x_nxt     = avg_x_r;
    avg_y_nxt     = avg_y_r;
    prod_nxt      = prod_r;
    span_nxt      = span_r;
    neg_nxt       = neg_r;
    zero_nxt      = zero_r;
    scr_x_nxt     = scr_x_r;
    scr_y_nxt     = scr_y_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    clear         = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = '0;

    unique case (state_r)
      tcc_pkg::ST_IDLE: begin
        axis_nxt = 1'b0;
        if (take && last) begin
          state_nxt = tcc_pkg::ST_AVG_GO;
        end
      end

      // Average one axis: window sum over the valid count; too few valid samples end the window untouched.
      tcc_pkg::ST_AVG_GO: begin
        if (valid_count < tcc_pkg::CNT_W'(tcc_pkg::MIN_VALID)) begin
          touch_nxt = 1'b0;
          state_nxt = tcc_pkg::ST_FINISH;
        end else begin
          touch_nxt        = 1'b1;
          div_req.start    = 1'b1;
          div_req.dividend = tcc_pkg::DIV_W'(axis_r ? sum_y : sum_x);
          div_req.divisor  = tcc_pkg::DVS_W'(valid_count);
          state_nxt        = tcc_pkg::ST_AVG_WAIT;
        end
      end

      tcc_pkg::ST_AVG_WAIT: begin
        if (div_rsp.done) begin
          if (axis_r) begin
            avg_y_nxt = div_rsp.quotient[RAW_W-1:0];
            axis_nxt  = 1'b0;
            state_nxt = tcc_pkg::ST_MAP_MUL;
          end else begin
            avg_x_nxt = div_rsp.quotient[RAW_W-1:0];
            axis_nxt  = 1'b1;
            state_nxt = tcc_pkg::ST_AVG_GO;
          end
        end
      end

      // Scale the offset from the low bound by the screen extent.
      tcc_pkg::ST_MAP_MUL: begin
        prod_nxt  = tcc_pkg::DIV_W'(diff_abs[RAW_W-1:0]) * tcc_pkg::DIV_W'(top_sel);
        span_nxt  = span_abs[RAW_W-1:0];
        neg_nxt   = diff[RAW_W] ^ span[RAW_W];
        zero_nxt  = (span == '0);
        state_nxt = tcc_pkg::ST_MAP_GO;
      end

      tcc_pkg::ST_MAP_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = prod_r;
        div_req.divisor  = span_r;
        state_nxt        = tcc_pkg::ST_MAP_WAIT;
      end

      tcc_pkg::ST_MAP_WAIT: begin
        if (div_rsp.done) begin
          if (axis_r) begin
            scr_y_nxt = clamped;
            state_nxt = tcc_pkg::ST_FINISH;
          end else begin
            scr_x_nxt = clamped[tcc_pkg::COL_W-1:0];
            axis_nxt  = 1'b1;
            state_nxt = tcc_pkg::ST_MAP_MUL;
          end
        end
      end

      // Hand the result to the output register once it is free.
      tcc_pkg::ST_FINISH: begin
        if (slot_free) begin
          out_valid_nxt         = 1'b1;
          out_data_nxt.touched  = touch_r;
          out_data_nxt.screen_x = touch_r ? scr_x_r : '0;
          out_data_nxt.screen_y = touch_r ? scr_y_r : '0;
          clear                 = 1'b1;
          state_nxt             = tcc_pkg::ST_IDLE;
        end
      end

      default: state_nxt = tcc_pkg::ST_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tcc_pkg::ST_IDLE;
      axis_r      <= 1'b0;
      touch_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      axis_r      <= axis_nxt;
      touch_r     <= touch_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    avg_x_r    <= avg_x_nxt;
    avg_y_r    <= avg_y_nxt;
    prod_r     <= prod_nxt;
    span_r     <= span_nxt;
    neg_r      <= neg_nxt;
    zero_r     <= zero_nxt;
    scr_x_r    <= scr_x_nxt;
    scr_y_r    <= scr_y_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== src/tcc_div.sv =====
// Shared unsigned restoring divider, one quotient bit per cycle.
// Uses tcc_pkg for its widths and request/response structs.
module tcc_div (
  input  logic              clk,
  input  logic              rst_n,
  input  tcc_pkg::div_req_t req,
  output tcc_pkg::div_rsp_t rsp
);

  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [tcc_pkg::STEP_W-1:0]  step_r, step_nxt;
  logic [tcc_pkg::DIV_W-1:0]   dvd_r, dvd_nxt;
  logic [tcc_pkg::DVS_W-1:0]   dvs_r, dvs_nxt;
  logic [tcc_pkg::DVS_W-1:0]   rem_r, rem_nxt;
  logic [tcc_pkg::DVS_W:0]     trial;
  logic                        fits;

  // One restoring step: shift in the next dividend bit and try a subtract.
  always_comb begin
    trial    = {rem_r, dvd_r[tcc_pkg::DIV_W-1]};
    fits     = (trial >= {1'b0, dvs_r});
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      step_nxt = tcc_pkg::STEP_W'(tcc_pkg::DIV_W);
      dvd_nxt  = req.dividend;
      dvs_nxt  = req.divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt  = fits ? tcc_pkg::DVS_W'(trial - {1'b0, dvs_r})
                      : trial[tcc_pkg::DVS_W-1:0];
      dvd_nxt  = {dvd_r[tcc_pkg::DIV_W-2:0], fits};
      step_nxt = step_r - 1'b1;
      if (step_r == tcc_pkg::STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = dvd_r;

endmodule

// ===== src/tcc_accum.sv =====
// Window accumulator: sums valid samples and counts valid and total samples.
// Uses tcc_pkg for widths and the input beat struct.
module tcc_accum (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       take,
  input  tcc_pkg::in_beat_t          beat,
  input  logic                       clear,
  output logic [tcc_pkg::SUM_W-1:0]  sum_x,
  output logic [tcc_pkg::SUM_W-1:0]  sum_y,
  output logic [tcc_pkg::CNT_W-1:0]  valid_count,
  output logic                       last
);

  logic [tcc_pkg::SUM_W-1:0] sum_x_r, sum_x_nxt;
  logic [tcc_pkg::SUM_W-1:0] sum_y_r, sum_y_nxt;
  logic [tcc_pkg::CNT_W-1:0] vcnt_r, vcnt_nxt;
  logic [tcc_pkg::CNT_W-1:0] wcnt_r, wcnt_nxt;
  logic                      touch;

  // A sample with both readings zero carries no touch.
  always_comb begin
    touch     = (beat.raw_x != '0) || (beat.raw_y != '0);
    sum_x_nxt = sum_x_r;
    sum_y_nxt = sum_y_r;
    vcnt_nxt  = vcnt_r;
    wcnt_nxt  = wcnt_r;
    if (clear) begin
      sum_x_nxt = '0;
      sum_y_nxt = '0;
      vcnt_nxt  = '0;
      wcnt_nxt  = '0;
    end else if (take) begin
      wcnt_nxt = wcnt_r + 1'b1;
      if (touch) begin
        sum_x_nxt = sum_x_r + tcc_pkg::SUM_W'(beat.raw_x);
        sum_y_nxt = sum_y_r + tcc_pkg::SUM_W'(beat.raw_y);
        vcnt_nxt  = vcnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_x_r <= '0;
      sum_y_r <= '0;
      vcnt_r  <= '0;
      wcnt_r  <= '0;
    end else begin
      sum_x_r <= sum_x_nxt;
      sum_y_r <= sum_y_nxt;
      vcnt_r  <= vcnt_nxt;
      wcnt_r  <= wcnt_nxt;
    end
  end

  assign sum_x       = sum_x_r;
  assign sum_y       = sum_y_r;
  assign valid_count = vcnt_r;
  // The beat now offered closes the window.
  assign last        = (wcnt_r == tcc_pkg::CNT_W'(tcc_pkg::WINDOW_SAMPLES - 1));

endmodule
